// ----- hdl/cbez_pkg.sv -----
// Shared widths, constants and inter-stage types for the cubic Bezier point evaluator.
package cbez_pkg;

  localparam int INDEX_WIDTH = 7;
  localparam int T_WIDTH     = 17;  // Q1.16 weights, 0..65536
  localparam int FRAC_BITS   = 16;
  localparam int HALF_Q16    = 32768;
  localparam int ADDR_WIDTH  = 5;
  localparam int DATA_WIDTH  = 32;
  localparam int NUM_POINTS  = 4;

  typedef struct packed {
    logic valid;
    logic last;
  } stage_tag_t;

  typedef struct packed {
    logic [NUM_POINTS-1:0][T_WIDTH-1:0] w;
  } weights_t;

endpackage

// ----- hdl/cbez_regs.sv -----
// APB control point register file.
module cbez_regs import cbez_pkg::*; #(
  parameter int COORD_WIDTH = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ADDR_WIDTH-1:0]         paddr,
  input  logic [DATA_WIDTH-1:0]         pwdata,
  output logic [DATA_WIDTH-1:0]         prdata,
  output logic                          pready,
  output logic signed [COORD_WIDTH-1:0] ctrl_x [NUM_POINTS],
  output logic signed [COORD_WIDTH-1:0] ctrl_y [NUM_POINTS]
);

  localparam int NUM_REGS = 2 * NUM_POINTS;

  logic [COORD_WIDTH-1:0] ctrl_reg [NUM_REGS];
  logic [2:0]             reg_idx;
  logic                   wr_en;

  assign reg_idx = paddr[4:2];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;
  assign prdata  = DATA_WIDTH'($signed(ctrl_reg[reg_idx]));

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < NUM_REGS; k++) begin
        ctrl_reg[k] <= '0;
      end
    end else if (wr_en) begin
      ctrl_reg[reg_idx] <= pwdata[COORD_WIDTH-1:0];
    end
  end

  // registers alternate x, y per control point
  for (genvar k = 0; k < NUM_POINTS; k++) begin : g_map
    assign ctrl_x[k] = $signed(ctrl_reg[2*k]);
    assign ctrl_y[k] = $signed(ctrl_reg[2*k+1]);
  end

endmodule

// ----- hdl/cbez_weights.sv -----
// Index to t lookup and Bernstein weight pipeline (three register stages).
module cbez_weights import cbez_pkg::*; #(
  parameter int SEGMENTS = 100
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   en,
  input  logic                   in_valid,
  input  logic [INDEX_WIDTH-1:0] sample_index,
  output stage_tag_t             tag,
  output weights_t               weights
);

  localparam int PROD_W = 2 * T_WIDTH + 2;
  localparam int LUT_N  = 2 ** INDEX_WIDTH;

  function automatic logic [T_WIDTH-1:0] round_q16(input logic [PROD_W-1:0] v);
    logic [PROD_W-1:0] s;
    s = v + PROD_W'(HALF_Q16);
    return s[FRAC_BITS +: T_WIDTH];
  endfunction

  // {last, t}, index clamped to SEGMENTS
  logic [T_WIDTH:0] t_lut [LUT_N];

  for (genvar g = 0; g < LUT_N; g++) begin : g_lut
    localparam int IDX = (g > SEGMENTS) ? SEGMENTS : g;
    localparam int TV  = (IDX * 65536 + SEGMENTS / 2) / SEGMENTS;
    assign t_lut[g] = {(IDX == SEGMENTS) ? 1'b1 : 1'b0, T_WIDTH'(TV)};
  end

  stage_tag_t         a_tag, b_tag;
  logic [T_WIDTH-1:0] a_t, a_u;
  logic [T_WIDTH-1:0] b_t, b_u, b_t2, b_u2;
  logic [PROD_W-1:0]  tu2, t2u;

  assign a_u = T_WIDTH'(65536) - a_t;
  assign tu2 = PROD_W'(b_t) * PROD_W'(b_u2);
  assign t2u = PROD_W'(b_t2) * PROD_W'(b_u);

  always_ff @(posedge clk) begin
    if (rst) begin
      a_tag.valid <= 1'b0;
      b_tag.valid <= 1'b0;
      tag.valid   <= 1'b0;
    end else if (en) begin
      a_tag.valid <= in_valid;
      b_tag.valid <= a_tag.valid;
      tag.valid   <= b_tag.valid;
    end
    if (en) begin
      {a_tag.last, a_t} <= t_lut[sample_index];

      b_tag.last <= a_tag.last;
      b_t        <= a_t;
      b_u        <= a_u;
      b_t2       <= round_q16(PROD_W'(a_t) * PROD_W'(a_t));
      b_u2       <= round_q16(PROD_W'(a_u) * PROD_W'(a_u));

      tag.last     <= b_tag.last;
      weights.w[0] <= round_q16(PROD_W'(b_u2) * PROD_W'(b_u));
      weights.w[1] <= round_q16(tu2 + (tu2 << 1));
      weights.w[2] <= round_q16(t2u + (t2u << 1));
      weights.w[3] <= round_q16(PROD_W'(b_t2) * PROD_W'(b_t));
    end
  end

endmodule

// ----- hdl/cbez_blend.sv -----
// Weighted sum of four coordinates: multiply, pair sums, final sum with rounding and clamp.
module cbez_blend import cbez_pkg::*; #(
  parameter int COORD_WIDTH = 16
) (
  input  logic                          clk,
  input  logic                          en,
  input  weights_t                      weights,
  input  logic signed [COORD_WIDTH-1:0] ctrl [NUM_POINTS],
  output logic signed [COORD_WIDTH-1:0] point
);

  localparam int PW = COORD_WIDTH + T_WIDTH + 1;
  localparam int AW = PW + 2;
  localparam int RW = AW - FRAC_BITS;

  logic signed [PW-1:0]   prod [NUM_POINTS];
  logic signed [PW:0]     s01, s23;
  logic signed [AW-1:0]   acc;
  logic signed [RW-1:0]   r;
  logic [RW-COORD_WIDTH:0] top_bits;
  logic [COORD_WIDTH-1:0] sat;

  assign acc      = AW'(s01) + AW'(s23) + AW'(HALF_Q16);
  assign r        = acc[AW-1:FRAC_BITS];
  assign top_bits = r[RW-1:COORD_WIDTH-1];

  always_comb begin
    if ((&top_bits) || !(|top_bits)) begin
      sat = r[COORD_WIDTH-1:0];
    end else if (r[RW-1]) begin
      sat = {1'b1, {(COORD_WIDTH-1){1'b0}}};
    end else begin
      sat = {1'b0, {(COORD_WIDTH-1){1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < NUM_POINTS; k++) begin
        prod[k] <= $signed({1'b0, weights.w[k]}) * ctrl[k];
      end
      s01   <= (PW+1)'(prod[0]) + (PW+1)'(prod[1]);
      s23   <= (PW+1)'(prod[2]) + (PW+1)'(prod[3]);
      point <= $signed(sat);
    end
  end

endmodule

// ----- hdl/cubic_bezier_point_eval_top.sv -----
// Top level of the cubic Bezier point evaluator.
//
// Sample channel: sample_valid / sample_stall carry one tessellation index per
// request. The curve parameter is t = index / SEGMENTS; an index past SEGMENTS
// is treated as SEGMENTS. Point channel: point_valid / point_stall carry
// point_x, point_y (signed Q2.14, saturated) and final_sample, set for the
// last sample of the curve. Control points sit in eight APB registers
// (x0, y0, x1, y1, x2, y2, x3, y3 at byte offsets 0, 4, ... 28); write them
// only while no request is in flight.
//
// Throughput: one request per cycle while sample_stall is low. Six register
// stages, the first loaded at the accepting edge: t lookup, squares,
// weights, coordinate products, pair sums, final sum with round and clamp.
// The whole pipe moves on one enable, so the output register doubles as the
// skid stage.
//
// Stall: while a point is held and point_stall is high, every stage freezes
// and sample_stall is raised; nothing is dropped or duplicated.
// Reset: clears all stage valid flags and the control points to zero.
module cubic_bezier_point_eval_top import cbez_pkg::*; #(
  parameter int SEGMENTS    = 100,
  parameter int COORD_WIDTH = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ADDR_WIDTH-1:0]         paddr,
  input  logic [DATA_WIDTH-1:0]         pwdata,
  output logic [DATA_WIDTH-1:0]         prdata,
  output logic                          pready,
  input  logic                          sample_valid,
  output logic                          sample_stall,
  input  logic [INDEX_WIDTH-1:0]        sample_index,
  output logic                          point_valid,
  input  logic                          point_stall,
  output logic signed [COORD_WIDTH-1:0] point_x,
  output logic signed [COORD_WIDTH-1:0] point_y,
  output logic                          final_sample
);

  logic                          adv;
  logic signed [COORD_WIDTH-1:0] ctrl_x [NUM_POINTS];
  logic signed [COORD_WIDTH-1:0] ctrl_y [NUM_POINTS];
  stage_tag_t                    c_tag, d_tag, e_tag, f_tag;
  weights_t                      weights;

  // pipe advances unless a finished point is being held
  assign adv          = !(point_valid && point_stall);
  assign sample_stall = !adv;

  cbez_regs #(
    .COORD_WIDTH(COORD_WIDTH)
  ) u_regs (
    .clk    (clk),
    .rst    (rst),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready),
    .ctrl_x (ctrl_x),
    .ctrl_y (ctrl_y)
  );

  cbez_weights #(
    .SEGMENTS(SEGMENTS)
  ) u_weights (
    .clk         (clk),
    .rst         (rst),
    .en          (adv),
    .in_valid    (sample_valid),
    .sample_index(sample_index),
    .tag         (c_tag),
    .weights     (weights)
  );

  cbez_blend #(
    .COORD_WIDTH(COORD_WIDTH)
  ) u_blend_x (
    .clk    (clk),
    .en     (adv),
    .weights(weights),
    .ctrl   (ctrl_x),
    .point  (point_x)
  );

  cbez_blend #(
    .COORD_WIDTH(COORD_WIDTH)
  ) u_blend_y (
    .clk    (clk),
    .en     (adv),
    .weights(weights),
    .ctrl   (ctrl_y),
    .point  (point_y)
  );

  // valid / last flags follow the three blend stages
  always_ff @(posedge clk) begin
    if (rst) begin
      d_tag.valid <= 1'b0;
      e_tag.valid <= 1'b0;
      f_tag.valid <= 1'b0;
    end else if (adv) begin
      d_tag.valid <= c_tag.valid;
      e_tag.valid <= d_tag.valid;
      f_tag.valid <= e_tag.valid;
    end
    if (adv) begin
      d_tag.last <= c_tag.last;
      e_tag.last <= d_tag.last;
      f_tag.last <= e_tag.last;
    end
  end

  assign point_valid  = f_tag.valid;
  assign final_sample = f_tag.last;

endmodule
